>>> rtl/ipv4_receive_header_check_unit_defines.svh
// ============================================================================
// ipv4 receive header check assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ============================================================================
`ifndef IPV4_RECEIVE_HEADER_CHECK_UNIT_DEFINES_SVH
`define IPV4_RECEIVE_HEADER_CHECK_UNIT_DEFINES_SVH

// same-cycle implication
`define IPV4RHC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IPV4RHC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ipv4rhc_pkg.sv
// ============================================================================
// ipv4rhc_pkg
// shared types and codes of the ipv4 receive header check unit
// ============================================================================
`timescale 1ns / 1ps

package ipv4rhc_pkg;

    localparam int WORD_W       = 16;
    localparam int ADDR_W       = 32;
    localparam int PROTO_W      = 8;
    localparam int VERDICT_W    = 3;
    localparam int COUNT_W      = 4;

    // word positions inside a 20-byte header
    localparam logic [COUNT_W-1:0] WORD_FIRST   = 4'd0;
    localparam logic [COUNT_W-1:0] WORD_FRAG    = 4'd3;
    localparam logic [COUNT_W-1:0] WORD_PROTO   = 4'd4;
    localparam logic [COUNT_W-1:0] WORD_CSUM    = 4'd5;
    localparam logic [COUNT_W-1:0] WORD_ADDR_HI = 4'd8;
    localparam logic [COUNT_W-1:0] WORD_LAST    = 4'd9;

    localparam logic [PROTO_W-1:0] PROTO_ICMP = 8'd1;
    localparam logic [PROTO_W-1:0] PROTO_TCP  = 8'd6;
    localparam logic [PROTO_W-1:0] PROTO_UDP  = 8'd17;

    localparam logic [VERDICT_W-1:0] VERDICT_ICMP     = 3'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_UDP      = 3'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_TCP      = 3'd2;
    localparam logic [VERDICT_W-1:0] VERDICT_UNKNOWN  = 3'd3;
    localparam logic [VERDICT_W-1:0] VERDICT_FRAG     = 3'd4;
    localparam logic [VERDICT_W-1:0] VERDICT_NOT_OURS = 3'd5;
    localparam logic [VERDICT_W-1:0] VERDICT_BAD_SUM  = 3'd6;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // classified header, passed from front to back
    typedef struct packed {
        logic               fragmented;
        logic               not_ours;
        logic               bad_sum;
        logic [PROTO_W-1:0] protocol;
    } hdr_class_t;

endpackage

>>> rtl/ipv4rhc_front.sv
// ============================================================================
// ipv4rhc_front
// takes header words, keeps the running sum and header fields, classifies
// ============================================================================
`timescale 1ns / 1ps
`include "ipv4_receive_header_check_unit_defines.svh"

module ipv4rhc_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                word_valid,
    input  logic [ipv4rhc_pkg::WORD_W-1:0]      header_word,
    input  logic                                first_word,
    input  logic [ipv4rhc_pkg::ADDR_W-1:0]      local_address,
    output logic                                class_valid,
    output ipv4rhc_pkg::hdr_class_t             class_data
);

    logic [ipv4rhc_pkg::COUNT_W-1:0]  count_reg, count_next;
    logic [ipv4rhc_pkg::WORD_W-1:0]   sum_reg, sum_next;
    logic [ipv4rhc_pkg::WORD_W-1:0]   csum_reg;
    logic                             frag_reg;
    logic [ipv4rhc_pkg::PROTO_W-1:0]  proto_reg;
    logic [ipv4rhc_pkg::WORD_W-1:0]   addr_hi_reg;

    logic [ipv4rhc_pkg::COUNT_W-1:0]  pos;
    logic [ipv4rhc_pkg::WORD_W-1:0]   sum_base;
    logic [ipv4rhc_pkg::WORD_W-1:0]   sum_added;

    // end-around carry add; the result never exceeds 16 bits
    function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        logic [16:0] f;
        s = {1'b0, a} + {1'b0, b};
        f = {1'b0, s[15:0]} + {16'd0, s[16]};
        return f[15:0];
    endfunction

    always_comb
    begin
        pos        = first_word ? ipv4rhc_pkg::WORD_FIRST : count_reg;
        sum_base   = (pos == ipv4rhc_pkg::WORD_FIRST) ? '0 : sum_reg;
        sum_added  = fold_add(sum_base, header_word);
        sum_next   = (pos == ipv4rhc_pkg::WORD_CSUM) ? sum_base : sum_added;
        count_next = (pos == ipv4rhc_pkg::WORD_LAST) ? ipv4rhc_pkg::WORD_FIRST
                                                     : pos + 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= ipv4rhc_pkg::WORD_FIRST;
        end
        else if (word_valid)
        begin
            count_reg <= count_next;
        end
    end

    // header fields and running sum; each is written before the last word reads it
    always_ff @(posedge clk)
    begin
        if (word_valid)
        begin
            sum_reg <= sum_next;
            if (pos == ipv4rhc_pkg::WORD_CSUM)
            begin
                csum_reg <= header_word;
            end
            if (pos == ipv4rhc_pkg::WORD_FRAG)
            begin
                frag_reg <= header_word[13] || (header_word[12:0] != 13'd0);
            end
            if (pos == ipv4rhc_pkg::WORD_PROTO)
            begin
                proto_reg <= header_word[7:0];
            end
            if (pos == ipv4rhc_pkg::WORD_ADDR_HI)
            begin
                addr_hi_reg <= header_word;
            end
        end
    end

    always_comb
    begin
        class_valid           = word_valid && (pos == ipv4rhc_pkg::WORD_LAST);
        class_data.fragmented = frag_reg;
        class_data.not_ours   = {addr_hi_reg, header_word} != local_address;
        class_data.bad_sum    = (~sum_added) != csum_reg;
        class_data.protocol   = proto_reg;
    end

    `IPV4RHC_ASSERT_NOW(a_count_range, 1'b1, count_reg <= ipv4rhc_pkg::WORD_LAST, "word count out of range")
    `IPV4RHC_ASSERT_NEXT(a_count_wrap, class_valid, count_reg == ipv4rhc_pkg::WORD_FIRST, "count did not wrap after last word")

endmodule

>>> rtl/ipv4rhc_queue.sv
// ============================================================================
// ipv4rhc_queue
// short register queue of classified headers between front and back
// ============================================================================
`timescale 1ns / 1ps
`include "ipv4_receive_header_check_unit_defines.svh"

module ipv4rhc_queue (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_valid,
    input  ipv4rhc_pkg::hdr_class_t  wr_data,
    output logic                     full,
    output logic                     rd_valid,
    output ipv4rhc_pkg::hdr_class_t  rd_data,
    input  logic                     rd_take
);

    ipv4rhc_pkg::hdr_class_t           slot_reg [ipv4rhc_pkg::QUEUE_DEPTH];
    logic [ipv4rhc_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [ipv4rhc_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [ipv4rhc_pkg::QCNT_W-1:0]    cnt_reg, cnt_next;
    logic                              do_wr, do_rd;

    localparam logic [ipv4rhc_pkg::QPTR_W-1:0] PTR_LAST =
        ipv4rhc_pkg::QPTR_W'(ipv4rhc_pkg::QUEUE_DEPTH - 1);
    localparam logic [ipv4rhc_pkg::QCNT_W-1:0] CNT_FULL =
        ipv4rhc_pkg::QCNT_W'(ipv4rhc_pkg::QUEUE_DEPTH);

    always_comb
    begin
        full     = cnt_reg == CNT_FULL;
        rd_valid = cnt_reg != '0;
        rd_data  = slot_reg[rd_ptr_reg];
        do_wr    = wr_valid && !full;
        do_rd    = rd_take && rd_valid;
        wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0
                                               : wr_ptr_reg + ipv4rhc_pkg::QPTR_W'(1);
        rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0
                                               : rd_ptr_reg + ipv4rhc_pkg::QPTR_W'(1);
        cnt_next = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + ipv4rhc_pkg::QCNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - ipv4rhc_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `IPV4RHC_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_reg <= CNT_FULL, "queue count above depth")
    `IPV4RHC_ASSERT_NOW(a_no_overflow, wr_valid, !full, "classified header dropped on full queue")

endmodule

>>> rtl/ipv4rhc_back.sv
// ============================================================================
// ipv4rhc_back
// turns a classified header into a verdict and holds it until popped
// ============================================================================
`timescale 1ns / 1ps
`include "ipv4_receive_header_check_unit_defines.svh"

module ipv4rhc_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 class_valid,
    input  ipv4rhc_pkg::hdr_class_t              class_data,
    output logic                                 class_take,
    output logic                                 empty,
    input  logic                                 pop,
    output logic [ipv4rhc_pkg::VERDICT_W-1:0]    verdict,
    output logic [ipv4rhc_pkg::PROTO_W-1:0]      protocol_number
);

    logic                                 out_valid_reg;
    logic [ipv4rhc_pkg::VERDICT_W-1:0]    verdict_reg, verdict_next;
    logic [ipv4rhc_pkg::PROTO_W-1:0]      proto_reg;

    always_comb
    begin
        priority if (class_data.fragmented)
            verdict_next = ipv4rhc_pkg::VERDICT_FRAG;
        else if (class_data.not_ours)
            verdict_next = ipv4rhc_pkg::VERDICT_NOT_OURS;
        else if (class_data.bad_sum)
            verdict_next = ipv4rhc_pkg::VERDICT_BAD_SUM;
        else if (class_data.protocol == ipv4rhc_pkg::PROTO_ICMP)
            verdict_next = ipv4rhc_pkg::VERDICT_ICMP;
        else if (class_data.protocol == ipv4rhc_pkg::PROTO_UDP)
            verdict_next = ipv4rhc_pkg::VERDICT_UDP;
        else if (class_data.protocol == ipv4rhc_pkg::PROTO_TCP)
            verdict_next = ipv4rhc_pkg::VERDICT_TCP;
        else
            verdict_next = ipv4rhc_pkg::VERDICT_UNKNOWN;
    end

    // refill the output register when it is free or being popped
    assign class_take = class_valid && (!out_valid_reg || pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (class_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (class_take)
        begin
            verdict_reg <= verdict_next;
            proto_reg   <= class_data.protocol;
        end
    end

    assign empty           = !out_valid_reg;
    assign verdict         = verdict_reg;
    assign protocol_number = proto_reg;

    `IPV4RHC_ASSERT_NEXT(a_hold_unpopped, out_valid_reg && !pop, out_valid_reg && $stable(verdict_reg), "waiting verdict lost")
    `IPV4RHC_ASSERT_NEXT(a_frag_first, class_take && class_data.fragmented, verdict_reg == ipv4rhc_pkg::VERDICT_FRAG, "fragment check lost priority")

endmodule

>>> rtl/ipv4_receive_header_check_unit.sv
// ============================================================================
// ipv4_receive_header_check_unit
// ipv4 header checksum and destination check with protocol verdict
// ============================================================================
// Header words enter one per cycle on push/full, ten per 20-byte header, with
// first_word restarting a header at any time. The front keeps the end-around
// carry sum and header fields and classifies the header on its tenth word;
// the classified header is registered in a two-entry queue between the
// classifier and the output register, and its verdict in that register.
// So full rises only when three verdicts wait unpopped, two in the queue
// and one in the output register; otherwise one word is taken every cycle.
// The local address is written through cfg_valid/cfg_data, which is always
// ready; it is compared on the tenth word of each header.
`timescale 1ns / 1ps

module ipv4_receive_header_check_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic [ipv4rhc_pkg::WORD_W-1:0]       header_word,
    input  logic                                 first_word,
    output logic                                 empty,
    input  logic                                 pop,
    output logic [ipv4rhc_pkg::VERDICT_W-1:0]    verdict,
    output logic [ipv4rhc_pkg::PROTO_W-1:0]      protocol_number,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ipv4rhc_pkg::ADDR_W-1:0]       cfg_data
);

    logic [ipv4rhc_pkg::ADDR_W-1:0]  local_address_reg;
    logic                            word_valid;
    logic                            class_valid;
    ipv4rhc_pkg::hdr_class_t         class_data;
    logic                            q_valid;
    ipv4rhc_pkg::hdr_class_t         q_data;
    logic                            q_take;

    assign cfg_ready  = 1'b1;
    assign word_valid = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_address_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            local_address_reg <= cfg_data;
        end
    end

    ipv4rhc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .word_valid    (word_valid),
        .header_word   (header_word),
        .first_word    (first_word),
        .local_address (local_address_reg),
        .class_valid   (class_valid),
        .class_data    (class_data)
    );

    ipv4rhc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (class_valid),
        .wr_data  (class_data),
        .full     (full),
        .rd_valid (q_valid),
        .rd_data  (q_data),
        .rd_take  (q_take)
    );

    ipv4rhc_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .class_valid     (q_valid),
        .class_data      (q_data),
        .class_take      (q_take),
        .empty           (empty),
        .pop             (pop),
        .verdict         (verdict),
        .protocol_number (protocol_number)
    );

endmodule

>>> tb/testbench.sv
// ============================================================================
// testbench
// ipv4 receive header check unit: directed and random header words, with
// each verdict checked against a typed table entry or a word-by-word predictor of the unit
// ============================================================================
// A short table of headers covers each verdict, the priority between
// verdicts, word extremes, mid-header restarts and the implicit restart
// after a tenth word. Random phases follow, each under its own local
// address: mostly well-formed headers with random content, some broken or
// truncated ones, and runs of raw noise words. Both sides insert random
// idle cycles. Results are compared field by field in order of arrival.
`timescale 1ns / 1ps

module testbench;

    import ipv4rhc_pkg::*;

    localparam int WATCHDOG_LIMIT = 200;
    localparam int SETTLE_CYCLES  = 4;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_HEADERS  = 30;
    localparam logic [ADDR_W-1:0] LOCAL_A = 32'hC0A8_0A01;

    typedef logic [9:0][WORD_W-1:0] hdr_words_t;

    typedef struct packed {
        logic [VERDICT_W-1:0] code;
        logic [PROTO_W-1:0]   proto;
    } verdict_rec_t;

    typedef struct packed {
        logic [PROTO_W-1:0]   proto;
        logic [WORD_W-1:0]    frag;
        logic [ADDR_W-1:0]    dst;
        logic [WORD_W-1:0]    fill;
        logic [WORD_W-1:0]    flip;
        logic [COUNT_W-1:0]   cut;
        logic                 lead;
        logic                 typed;
        logic [VERDICT_W-1:0] typed_verdict;
    } dir_row_t;

    // proto, frag word, destination, filler, checksum flip, cut, lead, typed, verdict
    localparam int DIR_ROWS = 19;
    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        '{PROTO_ICMP, 16'h0000, LOCAL_A, 16'h0000, 16'h0000, 4'd0, 1'b1, 1'b1, VERDICT_ICMP},
        '{PROTO_UDP,  16'h4000, LOCAL_A, 16'hFFFF, 16'h0000, 4'd0, 1'b1, 1'b0, VERDICT_ICMP},
        '{PROTO_TCP,  16'h0000, LOCAL_A, 16'h4500, 16'h0000, 4'd0, 1'b1, 1'b0, VERDICT_ICMP},
        '{8'hFF,      16'h0000, LOCAL_A, 16'hFFFF, 16'h0000, 4'd0, 1'b1, 1'b0, VERDICT_ICMP},
        '{8'h00,      16'h4000, LOCAL_A, 16'h1234, 16'h0000, 4'd0, 1'b1, 1'b0, VERDICT_ICMP},
        '{PROTO_UDP,  16'h2000, LOCAL_A, 16'h4500, 16'h0000, 4'd0, 1'b1, 1'b1, VERDICT_FRAG},
        '{PROTO_TCP,  16'h1FFF, LOCAL_A, 16'h4500, 16'h0000, 4'd0, 1'b1, 1'b1, VERDICT_FRAG},
        '{PROTO_ICMP, 16'hFFFF, LOCAL_A, 16'h0000, 16'h0000, 4'd0, 1'b1, 1'b1, VERDICT_FRAG},
        '{PROTO_ICMP, 16'h0000, LOCAL_A ^ 32'h0000_0001, 16'h4500, 16'h0000, 4'd0, 1'b1, 1'b1,
          VERDICT_NOT_OURS},
        '{PROTO_UDP,  16'h0000, LOCAL_A ^ 32'h8000_0000, 16'h4500, 16'h0000, 4'd0, 1'b1, 1'b1,
          VERDICT_NOT_OURS},
        '{PROTO_TCP,  16'h0000, LOCAL_A, 16'h4500, 16'h0001, 4'd0, 1'b1, 1'b1, VERDICT_BAD_SUM},
        '{PROTO_TCP,  16'h0000, LOCAL_A, 16'h4500, 16'h8000, 4'd0, 1'b0, 1'b1, VERDICT_BAD_SUM},
        '{PROTO_UDP,  16'h2001, LOCAL_A, 16'h4500, 16'hFFFF, 4'd0, 1'b1, 1'b1, VERDICT_FRAG},
        '{PROTO_ICMP, 16'h0000, ~LOCAL_A, 16'h4500, 16'h0F0F, 4'd0, 1'b1, 1'b1, VERDICT_NOT_OURS},
        '{PROTO_ICMP, 16'h0000, LOCAL_A, 16'h4500, 16'h0000, 4'd6, 1'b1, 1'b0, VERDICT_ICMP},
        '{PROTO_UDP,  16'h0000, LOCAL_A, 16'h4500, 16'h0000, 4'd0, 1'b1, 1'b0, VERDICT_ICMP},
        '{PROTO_TCP,  16'h0000, LOCAL_A, 16'hFFFF, 16'h0000, 4'd9, 1'b1, 1'b0, VERDICT_ICMP},
        '{PROTO_TCP,  16'h0000, LOCAL_A, 16'h0000, 16'h0000, 4'd0, 1'b1, 1'b0, VERDICT_ICMP},
        '{PROTO_ICMP, 16'h0000, LOCAL_A, 16'h4500, 16'h0000, 4'd0, 1'b0, 1'b0, VERDICT_ICMP}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 push;
    logic                 full;
    logic [WORD_W-1:0]    header_word;
    logic                 first_word;
    logic                 empty;
    logic                 pop;
    logic [VERDICT_W-1:0] verdict;
    logic [PROTO_W-1:0]   protocol_number;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [ADDR_W-1:0]    cfg_data;

    ipv4_receive_header_check_unit u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .header_word     (header_word),
        .first_word      (first_word),
        .empty           (empty),
        .pop             (pop),
        .verdict         (verdict),
        .protocol_number (protocol_number),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // header predictor state
    logic [COUNT_W-1:0] word_pos;
    logic [16:0]        sum_acc;
    logic [WORD_W-1:0]  csum_held;
    logic               frag_held;
    logic [WORD_W-1:0]  dst_hi_held;
    logic [PROTO_W-1:0] proto_held;
    logic [ADDR_W-1:0]  local_addr;

    verdict_rec_t verdict_due [$];
    int           fail_count;
    int           quiet_cycles;
    int           tx_run;
    bit           tx_calm;
    int           rx_run;
    bit           rx_calm;

    function automatic logic [16:0] ones_add(input logic [16:0] acc, input logic [WORD_W-1:0] w);
        logic [16:0] s;
        s = {1'b0, acc[15:0]} + {1'b0, w};
        s = {1'b0, s[15:0]} + {16'h0000, s[16]};
        return s;
    endfunction

    function automatic logic [WORD_W-1:0] header_csum(input hdr_words_t h);
        logic [16:0] acc;
        acc = '0;
        for (int i = 0; i < 10; i++)
        begin
            if (i != int'(WORD_CSUM))
                acc = ones_add(acc, h[i]);
        end
        return ~acc[15:0];
    endfunction

    function automatic hdr_words_t make_header(input hdr_words_t base,
                                               input logic [PROTO_W-1:0] proto,
                                               input logic [WORD_W-1:0] frag,
                                               input logic [ADDR_W-1:0] dst,
                                               input logic [WORD_W-1:0] flip);
        hdr_words_t h;
        h = base;
        h[WORD_FRAG]    = frag;
        h[WORD_PROTO]   = {base[WORD_PROTO][15:8], proto};
        h[WORD_ADDR_HI] = dst[31:16];
        h[WORD_LAST]    = dst[15:0];
        h[WORD_CSUM]    = header_csum(h) ^ flip;
        return h;
    endfunction

    // advances the predictor by one accepted word; returns 1 when a verdict is due
    function automatic bit classify_word(input logic [WORD_W-1:0] w, input logic fw,
                                         output verdict_rec_t r);
        logic [COUNT_W-1:0] k;
        k = fw ? WORD_FIRST : word_pos;
        if (k > WORD_LAST)
            k = WORD_FIRST;
        if (k == WORD_FIRST)
        begin
            sum_acc     = '0;
            csum_held   = '0;
            frag_held   = 1'b0;
            dst_hi_held = '0;
            proto_held  = '0;
        end
        if (k == WORD_CSUM)
            csum_held = w;
        else
            sum_acc = ones_add(sum_acc, w);
        if (k == WORD_FRAG)
            frag_held = w[13] || (w[12:0] != 13'd0);
        if (k == WORD_PROTO)
            proto_held = w[7:0];
        if (k == WORD_ADDR_HI)
            dst_hi_held = w;
        r = '0;
        if (k != WORD_LAST)
        begin
            word_pos = k + 4'd1;
            return 1'b0;
        end
        word_pos = WORD_FIRST;
        r.proto  = proto_held;
        if (frag_held)
            r.code = VERDICT_FRAG;
        else if ({dst_hi_held, w} != local_addr)
            r.code = VERDICT_NOT_OURS;
        else if (~sum_acc[15:0] != csum_held)
            r.code = VERDICT_BAD_SUM;
        else if (proto_held == PROTO_ICMP)
            r.code = VERDICT_ICMP;
        else if (proto_held == PROTO_UDP)
            r.code = VERDICT_UDP;
        else if (proto_held == PROTO_TCP)
            r.code = VERDICT_TCP;
        else
            r.code = VERDICT_UNKNOWN;
        return 1'b1;
    endfunction

    function automatic int tx_gap();
        if (tx_run == 0)
        begin
            tx_run  = $urandom_range(1, 12);
            tx_calm = ($urandom_range(0, 2) == 0);
        end
        tx_run--;
        return tx_calm ? 0 : $urandom_range(0, 8);
    endfunction

    function automatic int rx_stall();
        if (rx_run == 0)
        begin
            rx_run  = $urandom_range(1, 6);
            rx_calm = ($urandom_range(0, 2) == 0);
        end
        rx_run--;
        return rx_calm ? 0 : $urandom_range(0, 8);
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endfunction

    // one word request; push stays high when the next word follows at once
    task automatic send_word(input logic [WORD_W-1:0] w, input logic fw, input bit use_typed,
                             input verdict_rec_t typed_rec);
        int           gap;
        verdict_rec_t r;
        gap = tx_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push        <= 1'b1;
        header_word <= w;
        first_word  <= fw;
        @(posedge clk);
        while (full)
            @(posedge clk);
        if (classify_word(w, fw, r))
            verdict_due.push_back(use_typed ? typed_rec : r);
    endtask

    task automatic send_header(input hdr_words_t h, input logic lead, input logic [COUNT_W-1:0] cut,
                               input bit typed, input verdict_rec_t rec);
        int n;
        n = (cut == '0) ? 10 : int'(cut);
        for (int i = 0; i < n; i++)
            send_word(h[i], (i == 0) ? lead : 1'b0, typed, rec);
    endtask

    task automatic send_random_header();
        hdr_words_t         h;
        logic [PROTO_W-1:0] pr;
        logic [WORD_W-1:0]  fr;
        logic [ADDR_W-1:0]  da;
        logic [WORD_W-1:0]  fl;
        logic [COUNT_W-1:0] cut;
        int                 sel;
        int                 n;
        sel = $urandom_range(0, 99);
        if (sel < 18)
        begin
            // raw noise, restarts anywhere
            n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++)
                send_word(16'($urandom), ($urandom_range(0, 3) == 0), 1'b0, '0);
            return;
        end
        for (int i = 0; i < 10; i++)
            h[i] = 16'($urandom);
        case ($urandom_range(0, 4))
            0:       pr = PROTO_ICMP;
            1:       pr = PROTO_UDP;
            2:       pr = PROTO_TCP;
            default: pr = 8'($urandom);
        endcase
        fr = 16'($urandom);
        if ($urandom_range(0, 4) != 0)
            fr[13:0] = '0;
        case ($urandom_range(0, 9))
            0:       da = $urandom;
            1:       da = local_addr ^ (32'h1 << $urandom_range(0, 31));
            default: da = local_addr;
        endcase
        fl  = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(1, 65535)) : 16'h0000;
        cut = ($urandom_range(0, 11) == 0) ? 4'($urandom_range(1, 9)) : 4'd0;
        send_header(make_header(h, pr, fr, da, fl), ($urandom_range(0, 5) != 0), cut, 1'b0, '0);
    endtask

    // sender holds off until every verdict has been taken
    task automatic drain();
        push <= 1'b0;
        while (verdict_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_local_address(input logic [ADDR_W-1:0] a);
        cfg_valid <= 1'b1;
        cfg_data  <= a;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid  <= 1'b0;
        local_addr = a;
    endtask

    initial
    begin
        dir_row_t          row;
        verdict_rec_t      rec;
        logic [ADDR_W-1:0] a;
        rst_n       = 1'b0;
        push        = 1'b0;
        header_word = '0;
        first_word  = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        word_pos    = WORD_FIRST;
        sum_acc     = '0;
        csum_held   = '0;
        frag_held   = 1'b0;
        dst_hi_held = '0;
        proto_held  = '0;
        local_addr  = '0;
        fail_count  = 0;
        tx_run      = 0;
        tx_calm     = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_local_address(LOCAL_A);
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            row      = DIR_TAB[i];
            rec.code  = row.typed_verdict;
            rec.proto = row.proto;
            send_header(make_header({10{row.fill}}, row.proto, row.frag, row.dst, row.flip),
                        row.lead, row.cut, row.typed, rec);
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            drain();
            case (p)
                0:       a = 32'h0000_0000;
                1:       a = 32'hFFFF_FFFF;
                5:       a = 32'h8000_0001;
                default: a = $urandom;
            endcase
            write_local_address(a);
            for (int h = 0; h < PHASE_HEADERS; h++)
            begin
                if (h == PHASE_HEADERS / 2)
                    drain();
                send_random_header();
            end
        end

        drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && verdict_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // result side
    initial
    begin
        verdict_rec_t exp_rec;
        int           stall;
        pop     = 1'b0;
        rx_run  = 0;
        rx_calm = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = rx_stall();
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
            if (verdict_due.size() == 0)
            begin
                note_failure($sformatf("unexpected result: verdict %0d protocol %0d",
                                       verdict, protocol_number));
            end
            else
            begin
                exp_rec = verdict_due.pop_front();
                if (verdict !== exp_rec.code || protocol_number !== exp_rec.proto)
                    note_failure($sformatf(
                        "mismatch: verdict exp %0d got %0d, protocol exp %0d got %0d",
                        exp_rec.code, verdict, exp_rec.proto, protocol_number));
            end
        end
    end

    // ends a hung run
    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles = 0;
        else if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/ipv4rhc_pkg.sv
rtl/ipv4rhc_front.sv
rtl/ipv4rhc_queue.sv
rtl/ipv4rhc_back.sv
rtl/ipv4_receive_header_check_unit.sv
tb/testbench.sv
